[sv/mpst_pkg.sv]
// Shared types, widths and constants for the scanned pot EMA/taper block.
package mpst_pkg;

    // Build-time defaults
    localparam int CHANNELS_PER_MUX_DEF = 8;
    localparam int MUX_BANKS_DEF        = 3;
    localparam int POT_COUNT_DEF        = 24;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int POT_IDX_W = 5;
    localparam int MUX_SEL_W = 3;
    localparam int SHAPED_W  = 16;
    localparam int ALPHA_W   = 16;
    localparam int DEAD_W    = 12;
    localparam int STATE_W   = 28;
    localparam int BANK_W    = 2;

    // Shared unit widths
    localparam int MUL_A_W   = 17;
    localparam int MUL_B_W   = 28;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int TRIAL_W   = 13;
    localparam int QUOT_W    = 17;
    localparam int DIV_CNT_W = 5;

    // APB
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_ALPHA = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_DEAD  = 1'b1;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_POT   = 1'b1;

    localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 16'd6554;
    localparam logic [DEAD_W-1:0]   DEAD_RESET  = 12'd25;
    localparam logic [SAMPLE_W-1:0] ADC_FULL    = 12'd4095;
    localparam logic [MUL_A_W-1:0]  ONE_Q16     = 17'h10000;
    localparam logic [SHAPED_W-1:0] SHAPED_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [MUL_A_W-1:0]  mul_a;
        logic [MUL_B_W-1:0]  mul_b;
        logic [TRIAL_W-1:0]  trial;
        logic [SAMPLE_W-1:0] divisor;
    } t_unit_req;

    typedef struct packed {
        logic [PROD_W-1:0]  product;
        logic               fits;
        logic [TRIAL_W-1:0] diff;
    } t_unit_rsp;

endpackage

[sv/mpst_in_if.sv]
// Input channel: one conversion beat or one pot-process beat.
interface mpst_in_if;
    import mpst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [SAMPLE_W-1:0]  sample_bank0;
    logic [SAMPLE_W-1:0]  sample_bank1;
    logic [SAMPLE_W-1:0]  sample_bank2;
    logic [POT_IDX_W-1:0] pot_index;

    modport source (
        output valid, opcode, sample_bank0, sample_bank1, sample_bank2, pot_index,
        input  ready
    );

    modport sink (
        input  valid, opcode, sample_bank0, sample_bank1, sample_bank2, pot_index,
        output ready
    );
endinterface

[sv/mpst_out_if.sv]
// Output channel: one result beat per input beat.
interface mpst_out_if;
    import mpst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MUX_SEL_W-1:0] mux_select;
    logic [SAMPLE_W-1:0]  filtered_level;
    logic [SHAPED_W-1:0]  shaped_level;

    modport source (
        output valid, mux_select, filtered_level, shaped_level,
        input  ready
    );

    modport sink (
        input  valid, mux_select, filtered_level, shaped_level,
        output ready
    );
endinterface

[sv/mpst_ram.sv]
// Generic simple dual-port RAM, one write port, registered read.
module mpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/mpst_unit.sv]
// Shared arithmetic unit: one 17x28 multiplier and one restoring-divide step.
module mpst_unit (
    input  mpst_pkg::t_unit_req i_req,
    output mpst_pkg::t_unit_rsp o_rsp
);
    import mpst_pkg::*;

    logic [TRIAL_W-1:0] w_div_ext;

    assign w_div_ext     = {1'b0, i_req.divisor};
    assign o_rsp.product = PROD_W'(i_req.mul_a) * PROD_W'(i_req.mul_b);
    assign o_rsp.fits    = (i_req.trial >= w_div_ext);
    assign o_rsp.diff    = i_req.trial - w_div_ext;
endmodule

[sv/muxed_pot_scan_ema_taper_top.sv]
// Top level: APB registers, pot stores and the sequencer around the shared unit.
//
// Scanned potentiometer front end. An opcode 0 beat writes one sample per mux
// bank into the raw store (one bank per cycle through the single RAM write
// port) and advances the mux channel. An opcode 1 beat runs the EMA update
// (two multiplies through the shared unit, then an add), then the
// deadband/square taper: a level in the deadband gives zero and a full-scale
// dead zone gives full scale; otherwise the 17-step restoring divider that
// shares the unit's subtractor runs, followed by one squaring pass on the
// multiplier. An out of range pot index gives a zero result. One beat is
// worked at a time; the result sits in an output register so the next beat
// may be taken while it waits. Both stores read as zero after reset through
// per-entry valid bits.
module muxed_pot_scan_ema_taper_top #(
    parameter int CHANNELS_PER_MUX = mpst_pkg::CHANNELS_PER_MUX_DEF,
    parameter int MUX_BANKS        = mpst_pkg::MUX_BANKS_DEF,
    parameter int POT_COUNT        = mpst_pkg::POT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mpst_in_if.sink                      i_in,
    mpst_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpst_pkg::PADDR_W-1:0] paddr,
    input  logic [mpst_pkg::PDATA_W-1:0] pwdata,
    output logic [mpst_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import mpst_pkg::*;

    localparam int AW = $clog2(POT_COUNT);
    localparam int CW = $clog2(CHANNELS_PER_MUX);
    localparam int SW = $clog2(MUX_BANKS * CHANNELS_PER_MUX + 1);
    localparam logic [DIV_CNT_W-1:0] K_FIRST = DIV_CNT_W'(QUOT_W - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_MULA, S_MULB, S_ADD, S_TAPER, S_DIV, S_SQ, S_DONE
    } t_state;

    // Control
    t_state                r_state, n_state;
    logic [CW-1:0]         r_chan, n_chan;
    logic [BANK_W-1:0]     r_bank, n_bank;
    logic [DIV_CNT_W-1:0]  r_k, n_k;
    logic [POT_COUNT-1:0]  r_raw_vld, n_raw_vld;
    logic [POT_COUNT-1:0]  r_sm_vld, n_sm_vld;
    logic                  r_out_valid, n_out_valid;
    logic [ALPHA_W-1:0]    r_alpha, n_alpha;
    logic [DEAD_W-1:0]     r_dead, n_dead;

    // Payload
    logic                  r_opcode, n_opcode;
    logic [SAMPLE_W-1:0]   r_s0, n_s0, r_s1, n_s1, r_s2, n_s2;
    logic [AW-1:0]         r_p, n_p;
    logic                  r_raw_hit, n_raw_hit;
    logic                  r_sm_hit, n_sm_hit;
    logic [STATE_W-1:0]    r_acc, n_acc;
    logic [STATE_W-1:0]    r_prod, n_prod;
    logic [SAMPLE_W-1:0]   r_f, n_f;
    logic [SAMPLE_W-1:0]   r_rem, n_rem;
    logic [QUOT_W-1:0]     r_q, n_q;
    logic [SHAPED_W-1:0]   r_shaped, n_shaped;
    logic [MUX_SEL_W-1:0]  r_o_sel, n_o_sel;
    logic [SAMPLE_W-1:0]   r_o_filt, n_o_filt;
    logic [SHAPED_W-1:0]   r_o_shaped, n_o_shaped;

    // Datapath wires
    logic                  w_in_acc;
    logic                  w_p_ok;
    logic [AW-1:0]         w_p_in;
    logic [SW-1:0]         w_slot;
    logic                  w_slot_ok;
    logic [SAMPLE_W-1:0]   w_sample;
    logic                  w_raw_we;
    logic                  w_sm_we;
    logic [AW-1:0]         w_raddr;
    logic [SAMPLE_W-1:0]   w_raw_rd;
    logic [STATE_W-1:0]    w_sm_rd;
    logic [SAMPLE_W-1:0]   w_raw_val;
    logic [STATE_W-1:0]    w_sm_val;
    logic [STATE_W-1:0]    w_ns;
    logic [SAMPLE_W-1:0]   w_fd;
    logic [SAMPLE_W-1:0]   w_div;
    logic [QUOT_W:0]       w_sq;
    logic                  w_out_free;
    logic                  w_cfg_wr;
    logic [REG_IDX_W-1:0]  w_reg_idx;
    t_unit_req             w_req;
    t_unit_rsp             w_rsp;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            REG_ALPHA: prdata = PDATA_W'(r_alpha);
            REG_DEAD:  prdata = PDATA_W'(r_dead);
            default:   prdata = '0;
        endcase
    end

    // ---------------- stores ----------------
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_p_ok    = (32'(i_in.pot_index) < POT_COUNT);
    assign w_p_in    = AW'(i_in.pot_index);
    assign w_raddr   = (r_state == S_IDLE) ? w_p_in : r_p;

    assign w_slot    = SW'(r_bank) * SW'(CHANNELS_PER_MUX) + SW'(r_chan);
    assign w_slot_ok = (32'(w_slot) < POT_COUNT);
    assign w_raw_we  = (r_state == S_WR) && w_slot_ok;
    assign w_sm_we   = (r_state == S_ADD);

    always_comb begin
        case (r_bank)
            2'd0:    w_sample = r_s0;
            2'd1:    w_sample = r_s1;
            default: w_sample = r_s2;
        endcase
    end

    mpst_ram #(.WIDTH(SAMPLE_W), .DEPTH(POT_COUNT)) u_raw_ram (
        .i_clk   (i_clk),
        .i_we    (w_raw_we),
        .i_waddr (AW'(w_slot)),
        .i_wdata (w_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_raw_rd)
    );

    mpst_ram #(.WIDTH(STATE_W), .DEPTH(POT_COUNT)) u_sm_ram (
        .i_clk   (i_clk),
        .i_we    (w_sm_we),
        .i_waddr (r_p),
        .i_wdata (w_ns),
        .i_raddr (w_raddr),
        .o_rdata (w_sm_rd)
    );

    assign w_raw_val = r_raw_hit ? w_raw_rd : '0;
    assign w_sm_val  = r_sm_hit ? w_sm_rd : '0;
    assign w_ns      = r_acc + r_prod;
    assign w_fd      = r_f - r_dead;
    assign w_div     = ADC_FULL - r_dead;
    assign w_sq      = w_rsp.product[2*QUOT_W-1:16];

    // ---------------- shared unit ----------------
    always_comb begin
        w_req = '0;
        w_req.divisor = w_div;
        unique case (r_state)
            S_MULA: begin
                w_req.mul_a = MUL_A_W'(r_alpha);
                w_req.mul_b = MUL_B_W'(w_raw_val);
            end
            S_MULB: begin
                w_req.mul_a = ONE_Q16 - MUL_A_W'(r_alpha);
                w_req.mul_b = w_sm_val;
            end
            S_DIV: begin
                // first step folds the top 12 quotient bits: (f-d) <= divisor
                w_req.trial = (r_k == K_FIRST) ? TRIAL_W'(w_fd) : {r_rem, 1'b0};
            end
            S_SQ: begin
                w_req.mul_a = r_q;
                w_req.mul_b = MUL_B_W'(r_q);
            end
            default: ;
        endcase
    end

    mpst_unit u_unit (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // ---------------- sequencer ----------------
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_chan      = r_chan;
        n_bank      = r_bank;
        n_k         = r_k;
        n_raw_vld   = r_raw_vld;
        n_sm_vld    = r_sm_vld;
        n_out_valid = r_out_valid && !o_out.ready;
        n_alpha     = r_alpha;
        n_dead      = r_dead;
        n_opcode    = r_opcode;
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_p         = r_p;
        n_raw_hit   = r_raw_hit;
        n_sm_hit    = r_sm_hit;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_f         = r_f;
        n_rem       = r_rem;
        n_q         = r_q;
        n_shaped    = r_shaped;
        n_o_sel     = r_o_sel;
        n_o_filt    = r_o_filt;
        n_o_shaped  = r_o_shaped;

        if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_ALPHA: n_alpha = pwdata[ALPHA_W-1:0];
                REG_DEAD:  n_dead  = pwdata[DEAD_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_opcode  = i_in.opcode;
                    n_s0      = i_in.sample_bank0;
                    n_s1      = i_in.sample_bank1;
                    n_s2      = i_in.sample_bank2;
                    n_p       = w_p_in;
                    n_raw_hit = w_p_ok && r_raw_vld[w_p_in];
                    n_sm_hit  = w_p_ok && r_sm_vld[w_p_in];
                    n_f       = '0;
                    n_shaped  = '0;
                    n_bank    = '0;
                    if (i_in.opcode == OP_STORE) begin
                        n_state = S_WR;
                    end else if (w_p_ok) begin
                        n_state = S_MULA;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WR: begin
                if (w_slot_ok) begin
                    n_raw_vld[AW'(w_slot)] = 1'b1;
                end
                if (r_bank == BANK_W'(MUX_BANKS - 1)) begin
                    n_chan  = (32'(r_chan) == CHANNELS_PER_MUX - 1) ? '0 : r_chan + 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_bank = r_bank + 1'b1;
                end
            end
            S_MULA: begin
                n_acc   = w_rsp.product[STATE_W-1:0];
                n_state = S_MULB;
            end
            S_MULB: begin
                // (1-a)*s >> 16; the a*raw term has no fraction bits
                n_prod  = w_rsp.product[STATE_W+15:16];
                n_state = S_ADD;
            end
            S_ADD: begin
                n_sm_vld[r_p] = 1'b1;
                n_f           = w_ns[STATE_W-1:16];
                n_state       = S_TAPER;
            end
            S_TAPER: begin
                if (r_f < r_dead) begin
                    n_shaped = '0;
                    n_state  = S_DONE;
                end else if (r_dead == ADC_FULL) begin
                    n_shaped = SHAPED_MAX;
                    n_state  = S_DONE;
                end else begin
                    n_k     = K_FIRST;
                    n_q     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_rsp.fits ? w_rsp.diff[SAMPLE_W-1:0] : w_req.trial[SAMPLE_W-1:0];
                n_q   = {r_q[QUOT_W-2:0], w_rsp.fits};
                n_k   = r_k - 1'b1;
                if (r_k == '0) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_shaped = (w_sq > (QUOT_W+1)'(SHAPED_MAX)) ? SHAPED_MAX
                                                             : w_sq[SHAPED_W-1:0];
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_sel     = MUX_SEL_W'(r_chan);
                    n_o_filt    = r_f;
                    n_o_shaped  = r_shaped;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_opcode   <= n_opcode;
        r_s0       <= n_s0;
        r_s1       <= n_s1;
        r_s2       <= n_s2;
        r_p        <= n_p;
        r_raw_hit  <= n_raw_hit;
        r_sm_hit   <= n_sm_hit;
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_f        <= n_f;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_shaped   <= n_shaped;
        r_o_sel    <= n_o_sel;
        r_o_filt   <= n_o_filt;
        r_o_shaped <= n_o_shaped;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= '0;
            r_bank      <= '0;
            r_k         <= '0;
            r_raw_vld   <= '0;
            r_sm_vld    <= '0;
            r_out_valid <= 1'b0;
            r_alpha     <= ALPHA_RESET;
            r_dead      <= DEAD_RESET;
        end else begin
            r_state     <= n_state;
            r_chan      <= n_chan;
            r_bank      <= n_bank;
            r_k         <= n_k;
            r_raw_vld   <= n_raw_vld;
            r_sm_vld    <= n_sm_vld;
            r_out_valid <= n_out_valid;
            r_alpha     <= n_alpha;
            r_dead      <= n_dead;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.mux_select     = r_o_sel;
    assign o_out.filtered_level = r_o_filt;
    assign o_out.shaped_level   = r_o_shaped;

    // ---------------- assertions ----------------
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_k != K_FIRST) |-> (r_rem < w_div))
        else $error("divider remainder not below divisor");

    a_quot_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (r_q <= ONE_Q16))
        else $error("taper quotient above one");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_chan) < CHANNELS_PER_MUX)
        else $error("scan channel out of range");

    a_sm_write_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sm_we |-> (r_opcode == OP_POT && r_out_valid == $past(r_out_valid && !o_out.ready)))
        else $error("filter store written outside a pot beat");

endmodule

[test/testbench.sv]
// Testbench for the scanned pot EMA / deadband / square taper block.
module testbench;
    import mpst_pkg::*;

    typedef struct packed {
        logic                 opcode;
        logic [SAMPLE_W-1:0]  s0;
        logic [SAMPLE_W-1:0]  s1;
        logic [SAMPLE_W-1:0]  s2;
        logic [POT_IDX_W-1:0] pot;
    } t_scan_beat;

    typedef struct packed {
        logic [MUX_SEL_W-1:0] mux;
        logic [SAMPLE_W-1:0]  filtered;
        logic [SHAPED_W-1:0]  shaped;
    } t_level;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    mpst_in_if  in_bus();
    mpst_out_if out_bus();

    muxed_pot_scan_ema_taper_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [ALPHA_W-1:0]  alpha_cfg = ALPHA_RESET;
    logic [DEAD_W-1:0]   dead_cfg = DEAD_RESET;
    logic [MUX_SEL_W-1:0] scan_pos = '0;
    logic [SAMPLE_W-1:0] raw_levels [POT_COUNT_DEF];
    logic [STATE_W-1:0]  smooth_state [POT_COUNT_DEF];

    t_scan_beat pending_beats[$];
    t_level     expected_levels[$];
    int         err_count = 0;

    logic idle_on = 1'b1;
    logic hold_on = 1'b0;
    logic hold_go = 1'b0;
    int   src_gap = 0, src_run = 0, snk_gap = 0, snk_run = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("mismatch: %s", msg);
    endtask

    function automatic t_level predict_levels(input t_scan_beat b);
        t_level      r;
        logic [63:0] acc;
        logic [63:0] x;
        logic [63:0] sq;
        logic [SAMPLE_W-1:0] f;
        r = '0;
        if (b.opcode == OP_STORE) begin
            raw_levels[scan_pos]                        = b.s0;
            raw_levels[CHANNELS_PER_MUX_DEF + scan_pos]   = b.s1;
            raw_levels[2*CHANNELS_PER_MUX_DEF + scan_pos] = b.s2;
            if (scan_pos == CHANNELS_PER_MUX_DEF - 1) scan_pos = '0;
            else scan_pos = scan_pos + 1'b1;
        end else if (b.pot < POT_COUNT_DEF) begin
            acc = (64'(alpha_cfg) * (64'(raw_levels[b.pot]) << 16)
                   + (64'(ONE_Q16) - 64'(alpha_cfg)) * 64'(smooth_state[b.pot])) >> 16;
            smooth_state[b.pot] = acc[STATE_W-1:0];
            f = smooth_state[b.pot][STATE_W-1:16];
            r.filtered = f;
            if (f < dead_cfg) begin
                r.shaped = '0;
            end else if (dead_cfg == ADC_FULL) begin
                r.shaped = SHAPED_MAX;
            end else begin
                x = (64'(f - dead_cfg) << 16) / 64'(ADC_FULL - dead_cfg);
                sq = (x * x) >> 16;
                r.shaped = (sq > 64'(SHAPED_MAX)) ? SHAPED_MAX : sq[SHAPED_W-1:0];
            end
        end
        r.mux = scan_pos;
        return r;
    endfunction

    // input driver: offers queued beats, with random gaps while idle_on
    always @(posedge i_clk) begin : beat_driver
        t_scan_beat nb;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            src_gap <= 0;
            src_run <= 0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                in_bus.valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                nb = pending_beats.pop_front();
                in_bus.valid        <= 1'b1;
                in_bus.opcode       <= nb.opcode;
                in_bus.sample_bank0 <= nb.s0;
                in_bus.sample_bank1 <= nb.s1;
                in_bus.sample_bank2 <= nb.s2;
                in_bus.pot_index    <= nb.pot;
                if (src_run != 0) begin
                    src_run <= src_run - 1;
                end else if (idle_on) begin
                    src_gap <= $urandom_range(1, 8);
                    src_run <= $urandom_range(0, 30);
                end
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result ready: random stall bursts plus the long hold-off
    always @(posedge i_clk) begin : ready_driver
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            snk_gap <= 0;
            snk_run <= 0;
        end else if (hold_on) begin
            out_bus.ready <= 1'b0;
        end else if (snk_gap != 0) begin
            snk_gap <= snk_gap - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
            if (snk_run != 0) begin
                snk_run <= snk_run - 1;
            end else if (idle_on) begin
                snk_gap <= $urandom_range(1, 8);
                snk_run <= $urandom_range(0, 30);
            end
        end
    end

    // check result beats first so a same-edge input beat cannot cover a stray result
    always @(posedge i_clk) begin : beat_monitor
        t_level want;
        t_scan_beat got_in;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_levels.size() == 0) begin
                    report_error("result beat with nothing expected");
                end else begin
                    want = expected_levels.pop_front();
                    if (out_bus.mux_select !== want.mux)
                        report_error($sformatf("mux_select expected %0d got %0d",
                                               want.mux, out_bus.mux_select));
                    if (out_bus.filtered_level !== want.filtered)
                        report_error($sformatf("filtered_level expected %0d got %0d",
                                               want.filtered, out_bus.filtered_level));
                    if (out_bus.shaped_level !== want.shaped)
                        report_error($sformatf("shaped_level expected %0d got %0d",
                                               want.shaped, out_bus.shaped_level));
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                got_in = {in_bus.opcode, in_bus.sample_bank0, in_bus.sample_bank1,
                          in_bus.sample_bank2, in_bus.pot_index};
                expected_levels.push_back(predict_levels(got_in));
            end
        end
    end

    initial begin : receiver_hold
        wait (hold_go);
        @(negedge i_clk) hold_on = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_on = 1'b0;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, idx, value);
        if (idx == REG_ALPHA) alpha_cfg = value[ALPHA_W-1:0];
        else dead_cfg = value[DEAD_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        apb_access(1'b0, idx, '0);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ALPHA && rd[ALPHA_W-1:0] !== alpha_cfg)
            report_error($sformatf("alpha readback expected %0d got %0d", alpha_cfg, rd));
        if (idx == REG_DEAD && rd[DEAD_W-1:0] !== dead_cfg)
            report_error($sformatf("dead zone readback expected %0d got %0d", dead_cfg, rd));
    endtask

    task automatic set_config(input int alpha, input int dead);
        write_reg(REG_ALPHA, PDATA_W'(alpha));
        write_reg(REG_DEAD, PDATA_W'(dead));
    endtask

    // wait for all beats to drain, then cover the worst-case work latency
    task automatic drain;
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || in_bus.valid || expected_levels.size() != 0);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic t_scan_beat store_beat(input int a, input int b, input int c);
        t_scan_beat nb;
        nb.opcode = OP_STORE;
        nb.s0 = SAMPLE_W'(a);
        nb.s1 = SAMPLE_W'(b);
        nb.s2 = SAMPLE_W'(c);
        nb.pot = POT_IDX_W'($urandom);
        return nb;
    endfunction

    function automatic t_scan_beat pot_beat(input int idx);
        t_scan_beat nb;
        nb.opcode = OP_POT;
        nb.s0 = SAMPLE_W'($urandom);
        nb.s1 = SAMPLE_W'($urandom);
        nb.s2 = SAMPLE_W'($urandom);
        nb.pot = POT_IDX_W'(idx);
        return nb;
    endfunction

    // full scale, zero, or near the dead zone edge are favored
    function automatic int pick_sample;
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 4095;
            2: return dead_cfg ^ $urandom_range(0, 3);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // random runs of scan beats or of pot updates; a few out-of-range pots
    task automatic run_random(input int count);
        int n;
        @(negedge i_clk);
        while (count > 0) begin
            n = $urandom_range(1, 8);
            if ($urandom_range(0, 1) == 0) begin
                repeat (n) pending_beats.push_back(
                    store_beat(pick_sample(), pick_sample(), pick_sample()));
            end else begin
                repeat (n) pending_beats.push_back(pot_beat(
                    ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31)
                                                : $urandom_range(0, 23)));
            end
            count -= n;
        end
        drain();
    endtask

    initial begin : stimulus
        int pot_list[12];
        in_bus.valid = 1'b0;
        in_bus.opcode = OP_STORE;
        in_bus.sample_bank0 = '0;
        in_bus.sample_bank1 = '0;
        in_bus.sample_bank2 = '0;
        in_bus.pot_index = '0;
        out_bus.ready = 1'b0;
        pot_list = '{0, 1, 2, 7, 8, 9, 15, 16, 23, 24, 31, 0};
        foreach (raw_levels[k]) begin
            raw_levels[k] = '0;
            smooth_state[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extreme samples across one full sweep and the wrap
        pending_beats.push_back(store_beat(4095, 0, 4095));
        pending_beats.push_back(store_beat(0, 4095, 0));
        pending_beats.push_back(store_beat(12'hAAA, 12'h555, 12'hFFF));
        pending_beats.push_back(store_beat(12'h555, 12'hAAA, 12'h000));
        for (int k = 4; k < 8; k++)
            pending_beats.push_back(store_beat(4095, 4095 - k, k));
        foreach (pot_list[k])
            pending_beats.push_back(pot_beat(pot_list[k]));
        pending_beats.push_back(store_beat(1, 2, 3));
        drain();

        set_config(65535, 0);
        run_random(130);
        // alpha zero holds the state; full-scale dead zone
        set_config(0, 4095);
        run_random(40);
        set_config(1, 4094);
        run_random(100);
        set_config($urandom_range(1, 65535), $urandom_range(0, 4094));
        hold_go = 1'b1;
        run_random(150);
        set_config(65535, $urandom_range(0, 4094));
        run_random(130);
        idle_on = 1'b0;
        set_config($urandom_range(1, 65535), $urandom_range(0, 4094));
        run_random(150);

        repeat (40) @(negedge i_clk);
        if (err_count == 0 && expected_levels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
